FILE: rtl/core/cdt_pkg.sv
// Package for the code history dedup table: sizes, FSM state type and
// the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package cdt_pkg;

  // Table geometry
  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned CODE_BYTES = 32;
  localparam int unsigned BYTE_W     = 8;

  // Derived widths
  localparam int unsigned SLOT_W      = $clog2(ENTRIES);
  localparam int unsigned POS_W       = $clog2(CODE_BYTES);
  localparam int unsigned LEN_W       = $clog2(CODE_BYTES + 1);
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned MEM_AW      = SLOT_W + POS_W;
  localparam int unsigned MEM_DEPTH   = ENTRIES * (1 << POS_W);
  localparam int unsigned OUT_TDATA_W = ((1 + CNT_W + 7) / 8) * 8;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_COPY,
    ST_DONE
  } cdt_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;        // capture the incoming byte
    logic scan_issue;  // read the stored byte of the next entry
    logic decide;      // evaluate the match, write entry length
    logic copy_write;  // copy one staging byte into the table
    logic emit;        // load the result, update count, clear staging
  } cdt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;   // byte is stored and there are entries to compare
    logic in_last;     // tlast of the byte on the input
    logic last_q;      // captured byte closes the code
    logic scan_last;   // last entry read is being issued
    logic dup;         // combinational match result
    logic dup_q;       // registered match result
    logic copy_last;   // last staging byte is being copied
    logic out_busy;    // result register cannot take a new result
  } cdt_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/cdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdt_ctrl.sv
// Controller FSM of the code history dedup table: sequences byte intake,
// entry scan, match decision, table copy and result hand-off.
// Depends on cdt_pkg.
`default_nettype none

module cdt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire cdt_pkg::cdt_status_t status_i,
  output cdt_pkg::cdt_cmd_t        cmd_o
);

  import cdt_pkg::*;

  cdt_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.need_scan) begin
            state_d = ST_SCAN;
          end else if (status_i.in_last) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = status_i.last_q ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        state_d = status_i.dup ? ST_DONE : ST_COPY;
      end
      ST_COPY: begin
        if (status_i.copy_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_SCAN:   cmd_o.scan_issue = 1'b1;
      ST_DRAIN:  ;
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_COPY:   cmd_o.copy_write = 1'b1;
      ST_DONE:   cmd_o.emit = !status_i.out_busy;
      default:   ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdt_datapath.sv
// Datapath of the code history dedup table: staging buffer, entry lengths,
// per-entry match flags, entry byte RAM, counters and result register.
// Depends on cdt_pkg and cdt_ram.
`default_nettype none

module cdt_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [cdt_pkg::BYTE_W-1:0]   in_byte_i,
  input  wire logic                         in_last_i,
  input  wire cdt_pkg::cdt_cmd_t            cmd_i,
  output cdt_pkg::cdt_status_t              status_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              out_dup_o,
  output logic [cdt_pkg::CNT_W-1:0]         out_cnt_o
);

  import cdt_pkg::*;

  // Staging buffer and current byte
  logic [BYTE_W-1:0] staging_q [CODE_BYTES];
  logic [LEN_W-1:0]  stg_len_q;
  logic [BYTE_W-1:0] byte_q;
  logic [POS_W-1:0]  pos_q;
  logic              last_q;

  // Table bookkeeping
  logic [LEN_W-1:0]  len_q [ENTRIES];
  logic [CNT_W-1:0]  count_q;
  logic [SLOT_W-1:0] oldest_q;
  logic [ENTRIES-1:0] match_q;

  // Scan, decision and copy
  logic [SLOT_W-1:0] scan_e_q;
  logic              cmp_valid_q;
  logic [SLOT_W-1:0] cmp_idx_q;
  logic              dup_q;
  logic [SLOT_W-1:0] slot_q;
  logic [POS_W-1:0]  copy_i_q;

  // Result register
  logic              out_valid_q;
  logic              out_dup_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic [BYTE_W-1:0] rd_data;
  logic              pos_ok;
  logic              full;
  logic              dup;
  logic [SLOT_W-1:0] slot_d;
  logic [CNT_W-1:0]  count_nx;
  logic [ENTRIES-1:0] short_hit;

  assign pos_ok   = stg_len_q < LEN_W'(CODE_BYTES);
  assign full     = count_q == CNT_W'(ENTRIES);
  assign slot_d   = full ? oldest_q : count_q[SLOT_W-1:0];
  assign count_nx = (!dup_q && !full) ? count_q + CNT_W'(1) : count_q;

  // Per-entry checks: too short at this position, and final match
  always_comb begin
    dup       = 1'b0;
    short_hit = '0;
    for (int e = 0; e < ENTRIES; e++) begin
      if (CNT_W'(e) < count_q) begin
        short_hit[e] = len_q[e] <= LEN_W'(stg_len_q);
        if (match_q[e] && len_q[e] == stg_len_q) begin
          dup = 1'b1;
        end
      end
    end
  end

  // Entry byte storage: written by the copy, read by the scan
  cdt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_bytes (
    .clk_i   (clk_i),
    .we_i    (cmd_i.copy_write),
    .waddr_i ({slot_q, copy_i_q}),
    .wdata_i (staging_q[copy_i_q]),
    .raddr_i ({scan_e_q, pos_q}),
    .rdata_o (rd_data)
  );

  // Status to the controller
  always_comb begin
    status_o.need_scan = pos_ok && (count_q != '0);
    status_o.in_last   = in_last_i;
    status_o.last_q    = last_q;
    status_o.scan_last = scan_e_q == SLOT_W'(count_q - CNT_W'(1));
    status_o.dup       = dup;
    status_o.dup_q     = dup_q;
    status_o.copy_last = copy_i_q == POS_W'(stg_len_q - LEN_W'(1));
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

  // Payload registers without reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      byte_q <= in_byte_i;
      pos_q  <= stg_len_q[POS_W-1:0];
      last_q <= in_last_i;
      if (pos_ok) begin
        staging_q[stg_len_q[POS_W-1:0]] <= in_byte_i;
      end
    end
    if (cmd_i.decide) begin
      dup_q  <= dup;
      slot_q <= slot_d;
      if (!dup) begin
        len_q[slot_d] <= stg_len_q;
      end
    end
    if (cmd_i.emit) begin
      out_dup_q <= dup_q;
      out_cnt_q <= count_nx;
    end
    cmp_idx_q <= scan_e_q;
  end

  // Counters, staging length and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_len_q   <= '0;
      count_q     <= '0;
      oldest_q    <= '0;
      scan_e_q    <= '0;
      copy_i_q    <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_valid_q <= cmd_i.scan_issue;
      if (cmd_i.take) begin
        scan_e_q <= '0;
        if (pos_ok) begin
          stg_len_q <= stg_len_q + LEN_W'(1);
        end
      end else if (cmd_i.scan_issue) begin
        scan_e_q <= scan_e_q + SLOT_W'(1);
      end
      if (cmd_i.decide) begin
        copy_i_q <= '0;
      end else if (cmd_i.copy_write) begin
        copy_i_q <= copy_i_q + POS_W'(1);
      end
      if (cmd_i.emit) begin
        stg_len_q <= '0;
        count_q   <= count_nx;
        if (!dup_q && full) begin
          oldest_q <= (oldest_q == SLOT_W'(ENTRIES - 1)) ? '0 : oldest_q + SLOT_W'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Match flags: cleared on short entries and byte mismatches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '1;
    end else if (cmd_i.emit) begin
      match_q <= '1;
    end else begin
      if (cmd_i.take && pos_ok) begin
        match_q <= match_q & ~short_hit;
      end
      if (cmp_valid_q && rd_data != byte_q) begin
        match_q[cmp_idx_q] <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dup_o   = out_dup_q;
  assign out_cnt_o   = out_cnt_q;

endmodule

`default_nettype wire

FILE: rtl/core/code_history_dedup_table.sv
// Code history dedup table: keeps the most recent distinct codes and flags
// repeats. Input on the slave stream, one code byte per transfer, tlast on
// the final byte of a code. One result transfer per code on the master
// stream: tdata[0] = was_duplicate, tdata[CNT_W:1] = stored_count.
//
// Per accepted byte: the byte is captured in the idle state; when there is
// something to compare (table not empty and byte within the per-entry
// capacity), the stored entries are then walked one entry per cycle through
// the single read port of the entry byte RAM, followed by a drain state.
// After the final byte: a decision state, then copy states for a new code
// (none for a repeat), then a state that loads the result register.
// Reset empties the table and the staging buffer; no clearing pass runs.
// The result register holds a result until the receiver takes it; the
// next code's bytes are still accepted meanwhile, and the block only waits
// when a second result is ready before the first has been taken.
// Depends on cdt_pkg, cdt_ctrl, cdt_datapath and cdt_ram.
`default_nettype none

module code_history_dedup_table (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // slave stream, tdata: code_byte[7:0]; tlast: last_byte
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  // master stream, tdata: was_duplicate[0], stored_count[CNT_W:1], zero pad
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [cdt_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  import cdt_pkg::*;

  cdt_cmd_t    cmd;
  cdt_status_t status;
  logic        out_dup;
  logic [CNT_W-1:0] out_cnt;

  // Controller
  cdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  cdt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (s_axis_tdata[BYTE_W-1:0]),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_dup_o   (out_dup),
    .out_cnt_o   (out_cnt)
  );

  // Result packing
  assign m_axis_tdata = OUT_TDATA_W'({out_cnt, out_dup});

  // At most one datapath command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take, cmd.scan_issue, cmd.decide, cmd.copy_write, cmd.emit}))
    else $error("more than one datapath command active");

  // A repeated code is never copied into the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.copy_write |-> !status.dup_q)
    else $error("copy started for a duplicate code");

  // After any code the table holds at least one and at most ENTRIES codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_cnt != '0) && (out_cnt <= CNT_W'(ENTRIES)))
    else $error("stored count out of range");

  // A byte is only taken while the input handshake completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |-> s_axis_tvalid && s_axis_tready)
    else $error("byte captured without an input transfer");

endmodule

`default_nettype wire

FILE: bench/dedup_result_checker.sv
// Result checker for the code history dedup table: follows both stream channels,
// keeps its own copy of the code history and compares every result transfer.
// Depends on cdt_pkg for the table geometry and the result word layout.
module dedup_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,
  input  logic                            s_axis_tlast,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [cdt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                              fail_count_o,
  output int                              outstanding_o
);

  import cdt_pkg::*;

  // one predicted result per completed code
  typedef struct packed {
    logic             dup;
    logic [CNT_W-1:0] count;
  } verdict_t;

  // predicted table contents
  logic [7:0]       hist_bytes [ENTRIES][CODE_BYTES];
  logic [LEN_W-1:0] hist_len   [ENTRIES];
  logic [CNT_W-1:0] hist_count;
  logic [SLOT_W-1:0] hist_oldest;

  // code under assembly
  logic [7:0]       code_buf [CODE_BYTES];
  logic [LEN_W-1:0] code_len;

  verdict_t verdict_q[$];

  // Absorb one code byte; on the closing byte look the code up and insert it
  task automatic take_code_byte(input logic [7:0] b, input logic fin);
    int       e;
    int       i;
    int       slot;
    logic     hit;
    logic     same;
    verdict_t v;
    // bytes past the entry capacity are dropped
    if (code_len < CODE_BYTES) begin
      code_buf[code_len[POS_W-1:0]] = b;
      code_len = code_len + 1'b1;
    end
    if (fin) begin
      hit = 1'b0;
      for (e = 0; e < hist_count; e++) begin
        if (hist_len[e] == code_len) begin
          same = 1'b1;
          for (i = 0; i < code_len; i++)
            if (hist_bytes[e][i] != code_buf[i]) same = 1'b0;
          if (same) hit = 1'b1;
        end
      end
      // new code goes behind the newest entry, evicting the oldest when full
      if (!hit) begin
        slot = (int'(hist_oldest) + int'(hist_count)) % ENTRIES;
        hist_len[slot] = code_len;
        for (i = 0; i < code_len; i++) hist_bytes[slot][i] = code_buf[i];
        if (hist_count < ENTRIES) hist_count = hist_count + 1'b1;
        else hist_oldest = SLOT_W'((int'(hist_oldest) + 1) % ENTRIES);
      end
      v.dup   = hit;
      v.count = hist_count;
      verdict_q.push_back(v);
      code_len = '0;
    end
  endtask

  // Compare one result transfer with the oldest prediction
  task automatic check_verdict(input logic [OUT_TDATA_W-1:0] word);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      $error("unexpected result transfer, tdata=%0h", word);
      fail_count_o++;
    end else begin
      want = verdict_q.pop_front();
      if (word[0] !== want.dup) begin
        $error("was_duplicate: expected %0d, got %0d", want.dup, word[0]);
        fail_count_o++;
      end
      if (word[CNT_W:1] !== want.count) begin
        $error("stored_count: expected %0d, got %0d", want.count, word[CNT_W:1]);
        fail_count_o++;
      end
      if (word[OUT_TDATA_W-1:CNT_W+1] !== '0) begin
        $error("tdata pad: expected 0, got %0h", word[OUT_TDATA_W-1:CNT_W+1]);
        fail_count_o++;
      end
    end
  endtask

  // Results are checked before the byte of the same edge is taken, so a
  // stray result can never be matched with a code closing at that edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_count    = '0;
      hist_oldest   = '0;
      code_len      = '0;
      fail_count_o  = 0;
      verdict_q.delete();
      outstanding_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_verdict(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) take_code_byte(s_axis_tdata, s_axis_tlast);
      outstanding_o <= verdict_q.size();
    end
  end

endmodule

FILE: bench/code_history_dedup_table_tb.sv
// Testbench top for the code history dedup table: feeds codes byte by byte,
// throttles the result side and reports the verdict.
// Depends on cdt_pkg, code_history_dedup_table and dedup_result_checker.
module code_history_dedup_table_tb;
  import cdt_pkg::*;

  localparam int MAX_LEN   = CODE_BYTES + 8;
  localparam int BYTE_GOAL = 400;

  // a code as sent on the input stream, byte 0 first
  typedef struct packed {
    logic [5:0]                len;
    logic [MAX_LEN-1:0][7:0]   data;
  } code_rec_t;

  typedef enum {V_REPEAT, V_FLIP, V_SHORTEN, V_EXTEND, V_TAIL} variant_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int        fail_count;
  int        outstanding;
  int        bytes_sent;
  logic      hold_req;
  logic      calm;
  code_rec_t recent[$];

  code_history_dedup_table uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  dedup_result_checker result_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 8-unit clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Run limit
  initial begin
    #3200000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one byte, with random idle cycles ahead of it, until it transfers
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Send a whole code and remember it for later repeats
  task automatic issue(input code_rec_t c);
    int k;
    for (k = 0; k < c.len; k++) send_byte(c.data[k], k == c.len - 1);
    recent.push_back(c);
    if (recent.size() > 24) void'(recent.pop_front());
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic await_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic code_rec_t lit(input int n, input logic [31:0] w);
    code_rec_t c;
    c      = '0;
    c.len  = 6'(n);
    c.data[3:0] = w;
    return c;
  endfunction

  function automatic code_rec_t random_code(input int n);
    code_rec_t c;
    int        k;
    c     = '0;
    c.len = 6'(n);
    for (k = 0; k < n; k++) c.data[k] = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Mostly short codes, a few around and past the entry capacity
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 94) return $urandom_range(5, 12);
    return $urandom_range(CODE_BYTES - 2, MAX_LEN);
  endfunction

  // Derive a code from an earlier one: exact repeat or a near miss
  function automatic code_rec_t variant_of(input code_rec_t src, input variant_e kind);
    code_rec_t c;
    int        k;
    c = src;
    case (kind)
      V_FLIP: begin
        k = $urandom_range(0, c.len - 1);
        c.data[k] = c.data[k] ^ 8'($urandom_range(1, 255));
      end
      V_SHORTEN: begin
        if (c.len > 1) begin
          c.data[c.len-1] = '0;
          c.len = c.len - 1'b1;
        end else begin
          c.data[1] = 8'($urandom_range(0, 255));
          c.len = 6'd2;
        end
      end
      V_EXTEND: begin
        if (c.len < MAX_LEN) begin
          c.data[c.len] = 8'($urandom_range(0, 255));
          c.len = c.len + 1'b1;
        end
      end
      V_TAIL: begin
        // only the dropped bytes change, so this still counts as a repeat
        for (k = CODE_BYTES; k < c.len; k++)
          c.data[k] = c.data[k] ^ 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    return c;
  endfunction

  // Result side: random backpressure, one long hold-off, calm stretch
  initial begin : receiver
    int   hold_left;
    logic hold_used;
    m_axis_tready = 1'b0;
    hold_left     = 0;
    hold_used     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Input side stimulus and verdict
  initial begin : stimulus
    code_rec_t c;
    code_rec_t src;
    int        r;
    logic      drained;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    hold_req      = 1'b0;
    calm          = 1'b0;
    bytes_sent    = 0;
    drained       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte extremes, repeats, prefixes and same-length near misses
    issue(lit(1, 32'h00));
    issue(lit(1, 32'hFF));
    issue(lit(1, 32'h00));
    issue(lit(2, 32'hFF00));
    issue(lit(2, 32'hFE00));
    issue(lit(1, 32'hFF));
    issue(lit(4, 32'hFF0055AA));
    issue(lit(3, 32'h0055AA));
    issue(lit(4, 32'hFF0055AA));

    // capacity boundary: overlong code and its twin differing past the limit
    c = random_code(CODE_BYTES + 4);
    issue(c);
    issue(variant_of(c, V_TAIL));
    c = random_code(CODE_BYTES);
    issue(c);
    issue(c);

    // random codes, biased toward repeats and near misses of recent ones
    while (bytes_sent < BYTE_GOAL) begin
      if (bytes_sent >= 100 && !hold_req) hold_req <= 1'b1;
      if (bytes_sent >= 200 && !drained) begin
        await_results();
        drained = 1'b1;
      end
      calm <= (bytes_sent >= 250 && bytes_sent < 330);
      r   = $urandom_range(0, 99);
      src = recent[$urandom_range(0, recent.size() - 1)];
      if (r < 35)      c = random_code(pick_length());
      else if (r < 65) c = variant_of(src, V_REPEAT);
      else if (r < 75) c = variant_of(src, V_FLIP);
      else if (r < 83) c = variant_of(src, V_SHORTEN);
      else if (r < 90) c = variant_of(src, V_EXTEND);
      else             c = variant_of(src, V_TAIL);
      issue(c);
    end

    await_results();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
